### rtl/cbd_pkg.sv
package cbd_pkg;

  localparam int LANES      = 8;
  localparam int CELL_COUNT = 8;
  localparam int VOLT_W     = 13;
  localparam int DUTY_W     = 7;
  localparam int BAND_W     = 8;
  localparam int REG_W      = 13;
  localparam int REG_IDX_W  = 2;

  typedef logic [VOLT_W-1:0] volt_t;
  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [BAND_W-1:0] band_t;
  typedef logic [1:0]        action_t;
  typedef logic [LANES-1:0][VOLT_W-1:0] volt_vec_t;

  // action codes
  localparam action_t ACT_MEASURE = 2'd0;
  localparam action_t ACT_TOGGLE  = 2'd1;
  localparam action_t ACT_LOAD    = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_TERM_VOLT_MAX   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TERM_HYSTERESIS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TERM_RANGE      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_LIMIT      = 2'd3;

  localparam volt_t LOWEST_START = 13'd5000;
  localparam volt_t TERM_RESET   = 13'd3600;
  localparam duty_t DUTY_TOP     = 7'd100;

  localparam volt_t RST_TERM_VOLT_MAX   = 13'd3600;
  localparam band_t RST_TERM_HYSTERESIS = 8'd10;
  localparam band_t RST_TERM_RANGE      = 8'd20;
  localparam duty_t RST_DUTY_LIMIT      = 7'd75;

  // per-transaction control shared by all cell lanes
  typedef struct packed {
    logic    fire;
    action_t action;
    logic    active;
    volt_t   bound;
    duty_t   limit;
    band_t   hyst;
    volt_t   term_max;
  } lane_ctrl_t;

endpackage

### rtl/cbd_min_tree.sv
module cbd_min_tree (
  input  cbd_pkg::volt_vec_t values,
  output cbd_pkg::volt_t     lowest
);

  cbd_pkg::volt_t lvl0 [cbd_pkg::LANES];
  cbd_pkg::volt_t lvl1 [cbd_pkg::LANES/2];
  cbd_pkg::volt_t lvl2 [cbd_pkg::LANES/4];
  cbd_pkg::volt_t lvl3;

  // unused lanes sit at the start value so they never win
  always_comb begin
    for (int i = 0; i < cbd_pkg::LANES; i++) begin
      lvl0[i] = (i < cbd_pkg::CELL_COUNT) ? values[i] : cbd_pkg::LOWEST_START;
    end
    for (int i = 0; i < cbd_pkg::LANES/2; i++) begin
      lvl1[i] = (lvl0[2*i] < lvl0[2*i+1]) ? lvl0[2*i] : lvl0[2*i+1];
    end
    for (int i = 0; i < cbd_pkg::LANES/4; i++) begin
      lvl2[i] = (lvl1[2*i] < lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
    end
    lvl3   = (lvl2[0] < lvl2[1]) ? lvl2[0] : lvl2[1];
    lowest = (lvl3 < cbd_pkg::LOWEST_START) ? lvl3 : cbd_pkg::LOWEST_START;
  end

endmodule

### rtl/cbd_lane.sv
module cbd_lane (
  input  logic                clk,
  input  logic                rst,
  input  cbd_pkg::lane_ctrl_t ctrl,
  input  cbd_pkg::volt_t      value,
  output cbd_pkg::duty_t      duty
);

  cbd_pkg::volt_t            term;
  cbd_pkg::volt_t            term_raised;
  cbd_pkg::volt_t            term_next;
  cbd_pkg::duty_t            duty_next;
  logic [cbd_pkg::VOLT_W:0]  hyst_ext;
  logic                      step_up;
  logic                      step_down;

  always_comb begin
    hyst_ext    = {{(cbd_pkg::VOLT_W + 1 - cbd_pkg::BAND_W){1'b0}}, ctrl.hyst};
    term_raised = (term < ctrl.bound) ? ctrl.bound : term;
    // v > t + h and v + h < t, both in one extra bit
    step_up     = ({1'b0, term_raised} + hyst_ext) < {1'b0, value};
    step_down   = ({1'b0, value} + hyst_ext) < {1'b0, term_raised};

    duty_next = duty;
    term_next = term;
    case (ctrl.action)
      cbd_pkg::ACT_MEASURE: begin
        if (ctrl.active) begin
          term_next = term_raised;
          if (step_up && (duty < ctrl.limit)) begin
            duty_next = duty + 1'b1;
          end else if (step_down && (duty != '0)) begin
            duty_next = duty - 1'b1;
          end
        end else begin
          term_next = (value < ctrl.term_max) ? value : ctrl.term_max;
        end
      end
      cbd_pkg::ACT_TOGGLE: begin
        if (ctrl.active) begin
          duty_next = '0;
        end
      end
      cbd_pkg::ACT_LOAD: begin
        if (value > {{(cbd_pkg::VOLT_W - cbd_pkg::DUTY_W){1'b0}}, cbd_pkg::DUTY_TOP}) begin
          duty_next = cbd_pkg::DUTY_TOP;
        end else begin
          duty_next = value[cbd_pkg::DUTY_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty <= '0;
      term <= cbd_pkg::TERM_RESET;
    end else if (ctrl.fire) begin
      duty <= duty_next;
      term <= term_next;
    end
  end

endmodule

### rtl/cell_balance_duty_controller.sv
// Eight-cell bleed balancing controller.
// Input channel: in_valid / in_stall carry one transaction of an action code
// (measure, toggle balancing, load duties) and eight cell values. Output
// channel: out_valid / out_stall return one transaction per input with the
// balancing flag and the eight duties as they stand after that input.
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while no transaction is in flight.
// Stages: an accepted transaction moves from the input stage into the result
// stage once that is free. The first stage registers the item together with
// the lowest cell voltage from the min tree; the second updates the per-cell
// duty and termination registers, which are also the result registers.
// Throughput: one transaction per cycle while out_stall is low.
// Stall: a held result freezes the per-cell state; one further transaction
// is taken into the input stage, after which in_stall rises.
// Reset (synchronous, rst high): balancing off, duties zero, terminations
// 3600 mV, registers at their defaults, both channels empty.
module cell_balance_duty_controller (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [cbd_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [cbd_pkg::REG_W-1:0]       cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [12:0]                     cell_value_0,
  input  logic [12:0]                     cell_value_1,
  input  logic [12:0]                     cell_value_2,
  input  logic [12:0]                     cell_value_3,
  input  logic [12:0]                     cell_value_4,
  input  logic [12:0]                     cell_value_5,
  input  logic [12:0]                     cell_value_6,
  input  logic [12:0]                     cell_value_7,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            balancing_on,
  output logic [6:0]                      duty_0,
  output logic [6:0]                      duty_1,
  output logic [6:0]                      duty_2,
  output logic [6:0]                      duty_3,
  output logic [6:0]                      duty_4,
  output logic [6:0]                      duty_5,
  output logic [6:0]                      duty_6,
  output logic [6:0]                      duty_7
);

  // configuration registers
  cbd_pkg::volt_t term_volt_max;
  cbd_pkg::band_t term_hysteresis;
  cbd_pkg::band_t term_range;
  cbd_pkg::duty_t duty_limit;

  // input stage
  logic               s1_valid;
  cbd_pkg::action_t   s1_action;
  cbd_pkg::volt_vec_t s1_value;
  cbd_pkg::volt_t     s1_lowest;

  cbd_pkg::volt_vec_t in_value;
  cbd_pkg::volt_t     lowest;

  logic                        active;
  logic                        out_free;
  logic                        fire;
  logic                        in_fire;
  logic [cbd_pkg::VOLT_W:0]    bound_sum;
  cbd_pkg::volt_t              bound;
  cbd_pkg::duty_t              limit;
  cbd_pkg::lane_ctrl_t         ctrl;
  cbd_pkg::duty_t              lane_duty [cbd_pkg::LANES];

  assign in_value[0] = cell_value_0;
  assign in_value[1] = cell_value_1;
  assign in_value[2] = cell_value_2;
  assign in_value[3] = cell_value_3;
  assign in_value[4] = cell_value_4;
  assign in_value[5] = cell_value_5;
  assign in_value[6] = cell_value_6;
  assign in_value[7] = cell_value_7;

  // Handshake: the result stage advances when empty or taken; the input
  // stage drains into it and refills in the same cycle.
  assign out_free = !out_valid || !out_stall;
  assign fire     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_volt_max   <= cbd_pkg::RST_TERM_VOLT_MAX;
      term_hysteresis <= cbd_pkg::RST_TERM_HYSTERESIS;
      term_range      <= cbd_pkg::RST_TERM_RANGE;
      duty_limit      <= cbd_pkg::RST_DUTY_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        cbd_pkg::REG_TERM_VOLT_MAX:   term_volt_max   <= cfg_data[cbd_pkg::VOLT_W-1:0];
        cbd_pkg::REG_TERM_HYSTERESIS: term_hysteresis <= cfg_data[cbd_pkg::BAND_W-1:0];
        cbd_pkg::REG_TERM_RANGE:      term_range      <= cfg_data[cbd_pkg::BAND_W-1:0];
        cbd_pkg::REG_DUTY_LIMIT:      duty_limit      <= cfg_data[cbd_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Lowest-voltage search runs ahead of the input register.
  cbd_min_tree u_min_tree (
    .values (in_value),
    .lowest (lowest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload of the input stage needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action <= action;
      s1_value  <= in_value;
      s1_lowest <= lowest;
    end
  end

  // Termination floor: min(lowest + range, ceiling).
  always_comb begin
    bound_sum = {1'b0, s1_lowest}
              + {{(cbd_pkg::VOLT_W + 1 - cbd_pkg::BAND_W){1'b0}}, term_range};
    if (bound_sum < {1'b0, term_volt_max}) begin
      bound = bound_sum[cbd_pkg::VOLT_W-1:0];
    end else begin
      bound = term_volt_max;
    end
    limit = (duty_limit > cbd_pkg::DUTY_TOP) ? cbd_pkg::DUTY_TOP : duty_limit;
  end

  assign ctrl = '{
    fire:     fire,
    action:   s1_action,
    active:   active,
    bound:    bound,
    limit:    limit,
    hyst:     term_hysteresis,
    term_max: term_volt_max
  };

  // Balancing flag flips on a toggle.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (fire && (s1_action == cbd_pkg::ACT_TOGGLE)) begin
      active <= !active;
    end
  end

  // Result valid: set when a transaction completes, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // One lane per cell in use; lanes beyond the cell count read as zero.
  for (genvar i = 0; i < cbd_pkg::LANES; i++) begin : g_lane
    if (i < cbd_pkg::CELL_COUNT) begin : g_used
      cbd_lane u_lane (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .value (s1_value[i]),
        .duty  (lane_duty[i])
      );
    end else begin : g_unused
      assign lane_duty[i] = '0;
    end
  end

  // The per-cell state registers double as the result registers: they only
  // change when a new result is loaded.
  assign balancing_on = active;
  assign duty_0 = lane_duty[0];
  assign duty_1 = lane_duty[1];
  assign duty_2 = lane_duty[2];
  assign duty_3 = lane_duty[3];
  assign duty_4 = lane_duty[4];
  assign duty_5 = lane_duty[5];
  assign duty_6 = lane_duty[6];
  assign duty_7 = lane_duty[7];

`ifndef SYNTHESIS
  a_duty_in_range: assert property (@(posedge clk) disable iff (rst)
    (duty_0 <= cbd_pkg::DUTY_TOP) && (duty_1 <= cbd_pkg::DUTY_TOP) &&
    (duty_2 <= cbd_pkg::DUTY_TOP) && (duty_3 <= cbd_pkg::DUTY_TOP) &&
    (duty_4 <= cbd_pkg::DUTY_TOP) && (duty_5 <= cbd_pkg::DUTY_TOP) &&
    (duty_6 <= cbd_pkg::DUTY_TOP) && (duty_7 <= cbd_pkg::DUTY_TOP))
    else $error("duty above full scale");

  a_toggle_off_clears: assert property (@(posedge clk) disable iff (rst)
    fire && (s1_action == cbd_pkg::ACT_TOGGLE) && active |=>
      !balancing_on && (duty_0 == '0) && (duty_1 == '0) && (duty_2 == '0) &&
      (duty_3 == '0) && (duty_4 == '0) && (duty_5 == '0) && (duty_6 == '0) &&
      (duty_7 == '0))
    else $error("switching balancing off left a duty set");

  a_track_keeps_duty: assert property (@(posedge clk) disable iff (rst)
    fire && (s1_action == cbd_pkg::ACT_MEASURE) && !active |=>
      $stable(duty_0) && $stable(duty_3) && $stable(duty_7) && !balancing_on)
    else $error("measurement while inactive changed a duty");

  a_state_frozen_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(balancing_on) && $stable(duty_0))
    else $error("state moved while the result was held");
`endif

endmodule
